// ----- rtl/prq_pkg.sv -----
// Package for the prefetch request queue: widths, command and status codes,
// register indexes, and the types shared by the queue slots and the top level.
// Depends on nothing.
package prq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_BITS   = 48;
    localparam int TIME_BITS   = 48;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int CMD_W    = 2;
    localparam int DELAY_W  = 16;
    localparam int SPACE_W  = 8;
    localparam int STATUS_W = 2;
    localparam int BSL_W    = 4;
    localparam int LIMIT_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // Commands carried by an input item.
    localparam logic [CMD_W-1:0] CMD_MISS      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANDIDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ISSUE     = 2'd2;

    // Status codes of a result item.
    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ISSUED  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DROPPED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_LOG2  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERIAL_SQUASH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_AT_INSERT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_ONLY        = 3'd4;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        t_addr               addr;
        t_time               tick;
        logic [SPACE_W-1:0]  space;
    } t_entry;

    // Operation applied to every slot of the queue in the same cycle.
    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_COMPARE = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_POP     = 3'd3,
        OP_SQUASH  = 3'd4,
        OP_APPEND  = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_addr    key;
        t_addr    mask;
        t_time    miss_time;
        t_entry   fill;
    } t_cell_ctl;

endpackage

// ----- rtl/prefetch_request_queue.sv -----
// Top level of the prefetch request queue: sequencer, configuration
// registers, result register, and the chain of queue slots.
// Depends on prq_pkg and prq_cell.
//
// The queue is a row of QUEUE_DEPTH identical slots, head in slot 0, packed
// toward the head. Every cycle the sequencer broadcasts one operation to all
// slots (compare, remove-first-match, pop head, squash tail, append), and each
// slot takes its next entry from the slot above or from the broadcast fill.
// One item is worked on at a time. From the edge that accepts it, the item
// passes the compare state and ends in the done state, whose edge loads its
// result. An issue item, an unknown command, an ignored candidate or a
// rejected miss goes from compare straight to done. An accepted miss passes
// the remove state, and the squash state too with serial squash on. A skipped
// candidate passes the candidate state; an inserted one passes the candidate
// state and the evict state, which pops the head whenever the queue already
// holds queue_limit entries (several times after queue_limit was lowered
// below the fill level) and then appends. The sequencer steps the slot row
// one operation per cycle. The next item is accepted in idle, after the load.
// The result of an item sits in an output register; the next item is accepted
// as soon as the sequencer is back at rest, even if that result still waits,
// and the sequencer only stalls when it has a new result and the register is
// still full. Configuration writes take effect at once and are meant to be
// made while the block is idle.
module prefetch_request_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [prq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [prq_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Input items.
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [prq_pkg::CMD_W-1:0]        i_command,
    input  logic [prq_pkg::ADDR_BITS-1:0]    i_address,
    input  logic [prq_pkg::TIME_BITS-1:0]    i_event_time,
    input  logic [prq_pkg::DELAY_W-1:0]      i_delay,
    input  logic [prq_pkg::SPACE_W-1:0]      i_space_id,
    input  logic                             i_uncacheable,
    input  logic                             i_instruction_read,
    input  logic                             i_cached,
    input  logic                             i_in_miss_queue,
    // Result items.
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [prq_pkg::STATUS_W-1:0]     o_status,
    output logic [prq_pkg::ADDR_BITS-1:0]    o_out_address,
    output logic [prq_pkg::TIME_BITS-1:0]    o_out_time,
    output logic [prq_pkg::SPACE_W-1:0]      o_out_space_id,
    output logic                             o_pending,
    output logic                             o_bus_request,
    output logic [prq_pkg::TIME_BITS-1:0]    o_request_time
);
    import prq_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CMP    = 7'b0000010,
        ST_REMOVE = 7'b0000100,
        ST_SQUASH = 7'b0001000,
        ST_CAND   = 7'b0010000,
        ST_EVICT  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers.
    logic [BSL_W-1:0]   r_block_size_log2;
    logic [LIMIT_W-1:0] r_queue_limit;
    logic               r_serial_squash;
    logic               r_check_at_insert;
    logic               r_data_only;

    // Latched input item.
    logic [CMD_W-1:0]   r_cmd;
    t_addr              r_addr;
    t_time              r_etime;
    logic [DELAY_W-1:0] r_delay;
    logic [SPACE_W-1:0] r_space;
    logic               r_uncach;
    logic               r_iread;
    logic               r_cached;
    logic               r_inmq;

    // Miss context kept for the candidates that follow.
    t_time              r_last_time;
    logic [SPACE_W-1:0] r_last_space;
    logic               r_miss_acc;
    t_time              r_cand_time;

    // Result under construction.
    logic [STATUS_W-1:0] r_res_status;
    t_addr               r_res_addr;
    t_time               r_res_time;
    logic [SPACE_W-1:0]  r_res_space;
    logic                r_res_bus;
    t_time               r_res_rtime;

    // Output register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    t_addr               r_out_addr;
    t_time               r_out_time;
    logic [SPACE_W-1:0]  r_out_space;
    logic                r_out_pending;
    logic                r_out_bus;
    t_time               r_out_rtime;

    // Slot row.
    t_cell_ctl              w_ctl;
    t_entry                 w_entry   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic [QUEUE_DEPTH-1:0] w_hit;
    logic [QUEUE_DEPTH-1:0] w_tail_ok;

    t_addr            w_mask;
    logic [QIDX_W-1:0] w_lim_m1;
    logic             w_full;
    logic             w_accept;
    logic             w_miss_reject;
    logic             w_skip;
    logic             w_out_free;

    assign w_accept   = i_valid && o_ready;
    assign o_ready    = (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || i_ready;

    // Block mask from the configured block size.
    assign w_mask = ~((t_addr'(1) << r_block_size_log2) - t_addr'(1));

    // Effective limit minus one: zero acts as one, too large acts as the depth.
    always_comb begin
        if (32'(r_queue_limit) > QUEUE_DEPTH) begin
            w_lim_m1 = QIDX_W'(QUEUE_DEPTH - 1);
        end else if (r_queue_limit == '0) begin
            w_lim_m1 = '0;
        end else begin
            w_lim_m1 = QIDX_W'(32'(r_queue_limit) - 32'd1);
        end
    end

    assign w_full        = w_valid[w_lim_m1];
    assign w_miss_reject = r_uncach || (r_iread && r_data_only);
    assign w_skip        = (r_check_at_insert && r_cached) || r_inmq || (|w_match);

    // Slot control broadcast.
    always_comb begin
        w_ctl.op        = OP_HOLD;
        w_ctl.key       = (r_cmd == CMD_MISS) ? (r_addr & w_mask) : r_addr;
        w_ctl.mask      = w_mask;
        w_ctl.miss_time = r_etime;
        w_ctl.fill.addr  = r_addr;
        w_ctl.fill.tick  = r_cand_time;
        w_ctl.fill.space = r_last_space;
        unique case (r_state)
            ST_CMP: begin
                if (r_cmd == CMD_ISSUE) begin
                    w_ctl.op = OP_POP;
                end else if ((r_cmd == CMD_MISS) || (r_cmd == CMD_CANDIDATE)) begin
                    w_ctl.op = OP_COMPARE;
                end
            end
            ST_REMOVE: w_ctl.op = OP_REMOVE;
            ST_SQUASH: w_ctl.op = OP_SQUASH;
            ST_EVICT:  w_ctl.op = w_full ? OP_POP : OP_APPEND;
            default:   w_ctl.op = OP_HOLD;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if ((r_cmd == CMD_MISS) && !w_miss_reject) begin
                    n_state = ST_REMOVE;
                end else if ((r_cmd == CMD_CANDIDATE) && r_miss_acc) begin
                    n_state = ST_CAND;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_REMOVE: n_state = r_serial_squash ? ST_SQUASH : ST_DONE;
            ST_SQUASH: n_state = ST_DONE;
            ST_CAND:   n_state = w_skip ? ST_DONE : ST_EVICT;
            ST_EVICT: begin
                if (!w_full) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_block_size_log2 <= BSL_W'(6);
            r_queue_limit     <= LIMIT_W'(16);
            r_serial_squash   <= 1'b0;
            r_check_at_insert <= 1'b0;
            r_data_only       <= 1'b0;
            r_last_time       <= '0;
            r_last_space      <= '0;
            r_miss_acc        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_BLOCK_SIZE_LOG2: r_block_size_log2 <= i_cfg_wdata[BSL_W-1:0];
                    REG_QUEUE_LIMIT:     r_queue_limit     <= i_cfg_wdata[LIMIT_W-1:0];
                    REG_SERIAL_SQUASH:   r_serial_squash   <= i_cfg_wdata[0];
                    REG_CHECK_AT_INSERT: r_check_at_insert <= i_cfg_wdata[0];
                    REG_DATA_ONLY:       r_data_only       <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == ST_CMP) && (r_cmd == CMD_MISS) && w_miss_reject) begin
                r_miss_acc <= 1'b0;
            end
            if (r_state == ST_REMOVE) begin
                r_last_time  <= r_etime;
                r_last_space <= r_space;
                r_miss_acc   <= 1'b1;
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload, result and output registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd        <= i_command;
            r_addr       <= i_address;
            r_etime      <= i_event_time;
            r_delay      <= i_delay;
            r_space      <= i_space_id;
            r_uncach     <= i_uncacheable;
            r_iread      <= i_instruction_read;
            r_cached     <= i_cached;
            r_inmq       <= i_in_miss_queue;
            r_res_status <= STAT_DONE;
            r_res_addr   <= '0;
            r_res_time   <= '0;
            r_res_space  <= '0;
            r_res_bus    <= 1'b0;
            r_res_rtime  <= '0;
        end
        if (r_state == ST_CMP) begin
            // Candidate entry time wraps with the time width.
            r_cand_time <= r_last_time + t_time'(r_delay);
            if (r_cmd == CMD_ISSUE) begin
                if (!w_valid[0]) begin
                    r_res_status <= STAT_EMPTY;
                end else if (!r_check_at_insert && r_cached) begin
                    r_res_status <= STAT_DROPPED;
                end else begin
                    r_res_status <= STAT_ISSUED;
                    r_res_addr   <= w_entry[0].addr;
                    r_res_time   <= w_entry[0].tick;
                    r_res_space  <= w_entry[0].space;
                end
            end
        end
        if ((r_state == ST_EVICT) && !w_full) begin
            r_res_bus   <= 1'b1;
            r_res_rtime <= r_cand_time;
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_status  <= r_res_status;
            r_out_addr    <= r_res_addr;
            r_out_time    <= r_res_time;
            r_out_space   <= r_res_space;
            r_out_pending <= w_valid[0];
            r_out_bus     <= r_res_bus;
            r_out_rtime   <= r_res_rtime;
        end
    end

    // Chain of queue slots: slot 0 is the head, the top slot sees an empty
    // neighbor above it.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
        t_entry w_above;
        logic   w_above_valid;
        logic   w_above_tail_ok;
        logic   w_below_valid;
        logic   w_below_hit;

        if (g == QUEUE_DEPTH - 1) begin : g_top
            assign w_above         = w_entry[g];
            assign w_above_valid   = 1'b0;
            assign w_above_tail_ok = 1'b1;
        end else begin : g_mid
            assign w_above         = w_entry[g+1];
            assign w_above_valid   = w_valid[g+1];
            assign w_above_tail_ok = w_tail_ok[g+1];
        end

        if (g == 0) begin : g_head
            assign w_below_valid = 1'b1;
            assign w_below_hit   = 1'b0;
        end else begin : g_rest
            assign w_below_valid = w_valid[g-1];
            assign w_below_hit   = w_hit[g-1];
        end

        prq_cell u_slot (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (w_ctl),
            .i_above         (w_above),
            .i_above_valid   (w_above_valid),
            .i_above_tail_ok (w_above_tail_ok),
            .i_below_valid   (w_below_valid),
            .i_below_hit     (w_below_hit),
            .o_entry         (w_entry[g]),
            .o_valid         (w_valid[g]),
            .o_match         (w_match[g]),
            .o_hit           (w_hit[g]),
            .o_tail_ok       (w_tail_ok[g])
        );
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_address  = r_out_addr;
    assign o_out_time     = r_out_time;
    assign o_out_space_id = r_out_space;
    assign o_pending      = r_out_pending;
    assign o_bus_request  = r_out_bus;
    assign o_request_time = r_out_rtime;

endmodule

// ----- rtl/prq_cell.sv -----
// One slot of the prefetch request queue: holds one entry and its valid bit,
// and trades entries and chain signals with its two neighbors.
// Depends on prq_pkg.
module prq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prq_pkg::t_cell_ctl i_ctl,
    input  prq_pkg::t_entry    i_above,
    input  logic               i_above_valid,
    input  logic               i_above_tail_ok,
    input  logic               i_below_valid,
    input  logic               i_below_hit,
    output prq_pkg::t_entry    o_entry,
    output logic               o_valid,
    output logic               o_match,
    output logic               o_hit,
    output logic               o_tail_ok
);
    import prq_pkg::*;

    t_entry r_entry;
    logic   r_valid;
    logic   r_match;
    logic   w_ge;

    // A slot shifts down once a matching slot has been found at or below it.
    assign o_hit = i_below_hit || r_match;
    assign w_ge  = (r_entry.tick >= i_ctl.miss_time);
    // True when this slot and every valid slot above it may be squashed.
    assign o_tail_ok = !r_valid || (w_ge && i_above_tail_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                OP_COMPARE: begin
                    r_match <= r_valid && ((r_entry.addr & i_ctl.mask) == i_ctl.key);
                end
                OP_REMOVE: begin
                    if (o_hit) begin
                        r_valid <= i_above_valid;
                    end
                    r_match <= 1'b0;
                end
                OP_POP: begin
                    r_valid <= i_above_valid;
                    r_match <= 1'b0;
                end
                OP_SQUASH: begin
                    if (w_ge && i_above_tail_ok) begin
                        r_valid <= 1'b0;
                    end
                end
                OP_APPEND: begin
                    if (!r_valid && i_below_valid) begin
                        r_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_ctl.op == OP_POP) || ((i_ctl.op == OP_REMOVE) && o_hit)) begin
            r_entry <= i_above;
        end else if ((i_ctl.op == OP_APPEND) && !r_valid && i_below_valid) begin
            r_entry <= i_ctl.fill;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

// ----- tb/sv/prq_checker.sv -----
// Result checker for the prefetch request queue: holds its own copy of the
// queue, the settings and the last miss, predicts one result per accepted item
// and compares every delivered result with it. Depends on prq_pkg.
module prq_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [prq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [prq_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [prq_pkg::CMD_W-1:0]      i_command,
    input  logic [prq_pkg::ADDR_BITS-1:0]  i_address,
    input  logic [prq_pkg::TIME_BITS-1:0]  i_event_time,
    input  logic [prq_pkg::DELAY_W-1:0]    i_delay,
    input  logic [prq_pkg::SPACE_W-1:0]    i_space_id,
    input  logic                           i_uncacheable,
    input  logic                           i_instruction_read,
    input  logic                           i_cached,
    input  logic                           i_in_miss_queue,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [prq_pkg::STATUS_W-1:0]   i_status,
    input  logic [prq_pkg::ADDR_BITS-1:0]  i_out_address,
    input  logic [prq_pkg::TIME_BITS-1:0]  i_out_time,
    input  logic [prq_pkg::SPACE_W-1:0]    i_out_space_id,
    input  logic                           i_pending,
    input  logic                           i_bus_request,
    input  logic [prq_pkg::TIME_BITS-1:0]  i_request_time,
    output int                             o_mismatches,
    output int                             o_waiting
);
    import prq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_addr               addr;
        t_time               tick;
        logic [SPACE_W-1:0]  space;
        logic                pending;
        logic                bus_req;
        t_time               req_tick;
    } t_result;

    // Settings as last written.
    logic [BSL_W-1:0]   set_bsl;
    logic [LIMIT_W-1:0] set_limit;
    logic               set_squash;
    logic               set_at_insert;
    logic               set_data_only;

    // Shadow of the queue, head in slot 0.
    t_entry             slots [QUEUE_DEPTH];
    int                 fill;
    t_time              miss_tick;
    logic [SPACE_W-1:0] miss_space;
    logic               miss_live;

    t_result awaited_results [$];
    int      mismatch_count = 0;
    int      result_no = 0;

    function automatic t_addr block_base(input t_addr a);
        t_addr offset;
        offset = (t_addr'(1) << set_bsl) - t_addr'(1);
        return a & ~offset;
    endfunction

    task automatic drop_slot(input int pos);
        for (int i = pos; i + 1 < fill; i++) begin
            slots[i] = slots[i + 1];
        end
        fill--;
    endtask

    task automatic step_prefetch_queue(
        input  logic [CMD_W-1:0]   cmd,
        input  t_addr              addr,
        input  t_time              tick,
        input  logic [DELAY_W-1:0] dly,
        input  logic [SPACE_W-1:0] space,
        input  logic               unc,
        input  logic               iread,
        input  logic               cached,
        input  logic               inmq,
        output t_result            r
    );
        int     hit;
        int     lim;
        logic   skip;
        t_time  ready_tick;
        t_entry head;
        r = '0;
        case (cmd)
            CMD_MISS: begin
                if (unc || (iread && set_data_only)) begin
                    miss_live = 1'b0;
                end else begin
                    // The first queued entry in the missing block goes away.
                    hit = fill;
                    for (int i = fill - 1; i >= 0; i--) begin
                        if (block_base(slots[i].addr) == block_base(addr)) hit = i;
                    end
                    if (hit < fill) drop_slot(hit);
                    if (set_squash) begin
                        while (fill > 0 && slots[fill - 1].tick >= tick) fill--;
                    end
                    miss_tick  = tick;
                    miss_space = space;
                    miss_live  = 1'b1;
                end
            end
            CMD_CANDIDATE: begin
                if (miss_live) begin
                    ready_tick = miss_tick + t_time'(dly);
                    skip = (set_at_insert && cached) || inmq;
                    // Queued entries are masked, the candidate address is not.
                    for (int i = 0; i < fill; i++) begin
                        if (block_base(slots[i].addr) == addr) skip = 1'b1;
                    end
                    if (!skip) begin
                        lim = int'(set_limit);
                        if (lim < 1) lim = 1;
                        if (lim > QUEUE_DEPTH) lim = QUEUE_DEPTH;
                        while (fill >= lim) drop_slot(0);
                        slots[fill].addr  = addr;
                        slots[fill].tick  = ready_tick;
                        slots[fill].space = miss_space;
                        fill++;
                        r.bus_req  = 1'b1;
                        r.req_tick = ready_tick;
                    end
                end
            end
            CMD_ISSUE: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    head = slots[0];
                    drop_slot(0);
                    if (!set_at_insert && cached) begin
                        r.status = STAT_DROPPED;
                    end else begin
                        r.status = STAT_ISSUED;
                        r.addr   = head.addr;
                        r.tick   = head.tick;
                        r.space  = head.space;
                    end
                end
            end
            default: ;
        endcase
        r.pending = (fill != 0);
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_result exp_r;
        t_result got_r;
        t_result new_r;
        if (!i_rst_n) begin
            set_bsl       = 4'd6;
            set_limit     = 5'd16;
            set_squash    = 1'b0;
            set_at_insert = 1'b0;
            set_data_only = 1'b0;
            fill          = 0;
            miss_tick     = '0;
            miss_space    = '0;
            miss_live     = 1'b0;
            awaited_results.delete();
        end else begin
            // A result leaving now belongs to an item accepted earlier.
            if (i_out_valid && i_out_ready) begin
                got_r.status   = i_status;
                got_r.addr     = i_out_address;
                got_r.tick     = i_out_time;
                got_r.space    = i_out_space_id;
                got_r.pending  = i_pending;
                got_r.bus_req  = i_bus_request;
                got_r.req_tick = i_request_time;
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("prq_checker: result %0d arrived with none expected",
                                 result_no);
                    end
                end else begin
                    exp_r = awaited_results[0];
                    awaited_results.delete(0);
                    if (got_r.status !== exp_r.status || got_r.addr !== exp_r.addr ||
                        got_r.tick !== exp_r.tick || got_r.space !== exp_r.space ||
                        got_r.pending !== exp_r.pending ||
                        got_r.bus_req !== exp_r.bus_req ||
                        got_r.req_tick !== exp_r.req_tick) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("prq_checker: result %0d (expected/actual) status %0d/%0d",
                                     result_no, exp_r.status, got_r.status,
                                     " addr %h/%h time %h/%h",
                                     exp_r.addr, got_r.addr, exp_r.tick, got_r.tick);
                            $display("  space %h/%h pending %b/%b bus %b/%b req_time %h/%h",
                                     exp_r.space, got_r.space, exp_r.pending, got_r.pending,
                                     exp_r.bus_req, got_r.bus_req,
                                     exp_r.req_tick, got_r.req_tick);
                        end
                    end
                end
                result_no++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BLOCK_SIZE_LOG2: set_bsl       = i_cfg_wdata[BSL_W-1:0];
                    REG_QUEUE_LIMIT:     set_limit     = i_cfg_wdata[LIMIT_W-1:0];
                    REG_SERIAL_SQUASH:   set_squash    = i_cfg_wdata[0];
                    REG_CHECK_AT_INSERT: set_at_insert = i_cfg_wdata[0];
                    REG_DATA_ONLY:       set_data_only = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                step_prefetch_queue(i_command, i_address, i_event_time, i_delay,
                                    i_space_id, i_uncacheable, i_instruction_read,
                                    i_cached, i_in_miss_queue, new_r);
                awaited_results.insert(awaited_results.size(), new_r);
            end
        end
        o_mismatches <= mismatch_count;
        o_waiting    <= awaited_results.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the prefetch request queue: clock, reset, settings and
// item stimulus with random idling on both channels, and the final verdict.
// Depends on prq_pkg, prefetch_request_queue and prq_checker.
module tb_top;
    import prq_pkg::*;

    // The command code that the block must ignore has no name in the package.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 140;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        t_addr              addr;
        t_time              tick;
        logic [DELAY_W-1:0] dly;
        logic [SPACE_W-1:0] space;
        logic               unc, iread, cached, inmq;
    } t_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_valid;
    logic                  o_ready;
    logic [CMD_W-1:0]      i_command;
    logic [ADDR_BITS-1:0]  i_address;
    logic [TIME_BITS-1:0]  i_event_time;
    logic [DELAY_W-1:0]    i_delay;
    logic [SPACE_W-1:0]    i_space_id;
    logic                  i_uncacheable;
    logic                  i_instruction_read;
    logic                  i_cached;
    logic                  i_in_miss_queue;
    logic                  o_valid;
    logic                  i_ready;
    logic [STATUS_W-1:0]   o_status;
    logic [ADDR_BITS-1:0]  o_out_address;
    logic [TIME_BITS-1:0]  o_out_time;
    logic [SPACE_W-1:0]    o_out_space_id;
    logic                  o_pending;
    logic                  o_bus_request;
    logic [TIME_BITS-1:0]  o_request_time;

    int checker_mismatches;
    int checker_waiting;

    // Knobs shared between the stimulus and the result side.
    bit tx_gaps     = 1'b0;
    bit rx_gaps     = 1'b0;
    int rx_hold_len = 0;

    // The stimulus keeps the block size itself so that it can aim addresses at
    // whole blocks; the checker follows the register writes on its own.
    logic [BSL_W-1:0] cur_bsl;
    t_addr            blk_pool [8];
    t_time            tick_now;

    // Settings of the random phases. The queue limit runs through 0 (acts as 1),
    // 1, the depth, and values above the depth; the block size takes values from 0 to 15.
    logic [4:0] ph_bsl    [PHASES] = '{5'd15, 5'd0, 5'd12, 5'd6, 5'd3, 5'd9, 5'd1, 5'd6};
    logic [4:0] ph_limit  [PHASES] = '{5'd31, 5'd16, 5'd4, 5'd2, 5'd0, 5'd17, 5'd1, 5'd16};
    logic       ph_squash [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic       ph_insert [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    logic       ph_donly  [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
    logic       ph_txgap  [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    logic       ph_rxgap  [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    prefetch_request_queue u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_command          (i_command),
        .i_address          (i_address),
        .i_event_time       (i_event_time),
        .i_delay            (i_delay),
        .i_space_id         (i_space_id),
        .i_uncacheable      (i_uncacheable),
        .i_instruction_read (i_instruction_read),
        .i_cached           (i_cached),
        .i_in_miss_queue    (i_in_miss_queue),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_out_address      (o_out_address),
        .o_out_time         (o_out_time),
        .o_out_space_id     (o_out_space_id),
        .o_pending          (o_pending),
        .o_bus_request      (o_bus_request),
        .o_request_time     (o_request_time)
    );

    prq_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_valid),
        .i_in_ready         (o_ready),
        .i_command          (i_command),
        .i_address          (i_address),
        .i_event_time       (i_event_time),
        .i_delay            (i_delay),
        .i_space_id         (i_space_id),
        .i_uncacheable      (i_uncacheable),
        .i_instruction_read (i_instruction_read),
        .i_cached           (i_cached),
        .i_in_miss_queue    (i_in_miss_queue),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_status           (o_status),
        .i_out_address      (o_out_address),
        .i_out_time         (o_out_time),
        .i_out_space_id     (o_out_space_id),
        .i_pending          (o_pending),
        .i_bus_request      (o_bus_request),
        .i_request_time     (o_request_time),
        .o_mismatches       (checker_mismatches),
        .o_waiting          (checker_waiting)
    );

    always #6 i_clk = ~i_clk;

    // A random value across the whole address width; ticks have the same width.
    function automatic t_addr random_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_BITS-1:0];
    endfunction

    function automatic t_addr align_block(input t_addr a);
        return a & ~((t_addr'(1) << cur_bsl) - t_addr'(1));
    endfunction

    // An item with every field random. The builders below start from it, so the
    // fields that a command does not use still carry random values, which the
    // block has to ignore.
    function automatic t_item noise_item();
        t_item it;
        it.cmd    = CMD_W'($urandom_range(0, 3));
        it.addr   = random_addr();
        it.tick   = t_time'(random_addr());
        it.dly    = DELAY_W'($urandom);
        it.space  = SPACE_W'($urandom);
        it.unc    = 1'($urandom_range(0, 1));
        it.iread  = 1'($urandom_range(0, 1));
        it.cached = 1'($urandom_range(0, 1));
        it.inmq   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_item mk_miss(input t_addr a, input t_time t,
                                      input logic [SPACE_W-1:0] s,
                                      input logic unc, input logic iread);
        t_item it;
        it       = noise_item();
        it.cmd   = CMD_MISS;
        it.addr  = a;
        it.tick  = t;
        it.space = s;
        it.unc   = unc;
        it.iread = iread;
        return it;
    endfunction

    function automatic t_item mk_cand(input t_addr a, input logic [DELAY_W-1:0] d,
                                      input logic cached, input logic inmq);
        t_item it;
        it        = noise_item();
        it.cmd    = CMD_CANDIDATE;
        it.addr   = a;
        it.dly    = d;
        it.cached = cached;
        it.inmq   = inmq;
        return it;
    endfunction

    function automatic t_item mk_issue(input logic cached);
        t_item it;
        it        = noise_item();
        it.cmd    = CMD_ISSUE;
        it.cached = cached;
        return it;
    endfunction

    // Offers one item and returns at the edge that accepts it. Valid is left
    // high: the next item either follows at once, or whoever comes next lowers
    // valid in this same time step, so valid never drops and rises in one step.
    task automatic put_item(input t_item it);
        int gap;
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_command          <= it.cmd;
        i_address          <= it.addr;
        i_event_time       <= it.tick;
        i_delay            <= it.dly;
        i_space_id         <= it.space;
        i_uncacheable      <= it.unc;
        i_instruction_read <= it.iread;
        i_cached           <= it.cached;
        i_in_miss_queue    <= it.inmq;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Stops offering and waits until the checker holds no open expectation.
    // Every item yields exactly one result, so once the last one is out the
    // block is back at rest and settings may be written.
    task automatic wait_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (checker_waiting != 0);
    endtask

    // Writes all five registers on back-to-back edges; write enable stays high
    // across them and drops once after the last one.
    task automatic load_settings(input logic [4:0] bsl, input logic [4:0] lim,
                                 input logic squash, input logic at_insert,
                                 input logic donly);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_BLOCK_SIZE_LOG2;
        i_cfg_wdata <= bsl;
        @(posedge i_clk);
        i_cfg_idx   <= REG_QUEUE_LIMIT;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        i_cfg_idx   <= REG_SERIAL_SQUASH;
        i_cfg_wdata <= CFG_DATA_W'(squash);
        @(posedge i_clk);
        i_cfg_idx   <= REG_CHECK_AT_INSERT;
        i_cfg_wdata <= CFG_DATA_W'(at_insert);
        @(posedge i_clk);
        i_cfg_idx   <= REG_DATA_ONLY;
        i_cfg_wdata <= CFG_DATA_W'(donly);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_bsl     = bsl[BSL_W-1:0];
    endtask

    // Random traffic shaped like real use: a miss, a handful of candidates that
    // it triggers, and a few issue requests. Candidates mostly hit a small pool
    // of blocks so that duplicates, removals and evictions are common. About
    // one step in ten is an unshaped item instead: unknown commands, candidates
    // after a rejected miss, issues in odd places.
    task automatic run_phase(input int target);
        int    sent;
        int    n_cand;
        int    n_issue;
        int    pick;
        t_addr a;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                put_item(noise_item());
                sent++;
            end else begin
                // Miss times mostly move forward; now and then they step back,
                // which is what lets the serial squash pop tail entries.
                if ($urandom_range(0, 7) == 0) begin
                    tick_now = tick_now - t_time'($urandom_range(0, 500));
                end else begin
                    tick_now = tick_now + t_time'($urandom_range(0, 900));
                end
                if ($urandom_range(0, 4) == 0) begin
                    a = random_addr();
                end else begin
                    a = blk_pool[$urandom_range(0, 7)] | (random_addr() & ~align_block('1));
                end
                put_item(mk_miss(a, tick_now, SPACE_W'($urandom),
                                 $urandom_range(0, 11) == 0, $urandom_range(0, 3) == 0));
                n_cand = $urandom_range(1, 6);
                repeat (n_cand) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80) begin
                        a = blk_pool[$urandom_range(0, 7)];
                    end else if (pick < 92) begin
                        a = align_block(random_addr());
                    end else begin
                        a = random_addr();
                    end
                    put_item(mk_cand(a,
                                     ($urandom_range(0, 7) == 0) ?
                                         DELAY_W'($urandom) :
                                         DELAY_W'($urandom_range(0, 400)),
                                     $urandom_range(0, 3) == 0,
                                     $urandom_range(0, 6) == 0));
                end
                n_issue = $urandom_range(0, 4);
                repeat (n_issue) put_item(mk_issue($urandom_range(0, 3) == 0));
                sent += 1 + n_cand + n_issue;
            end
        end
    endtask

    // Result side: ready high most of the time, random stall bursts when asked
    // for, and one long hold-off on request so that the block backs up and
    // stalls its input while items keep being offered.
    initial begin : result_side
        int gap;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_len != 0) begin
                i_ready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 12);
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_item it;
        int    p;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= '0;
        i_cfg_wdata        <= '0;
        i_valid            <= 1'b0;
        i_command          <= '0;
        i_address          <= '0;
        i_event_time       <= '0;
        i_delay            <= '0;
        i_space_id         <= '0;
        i_uncacheable      <= 1'b0;
        i_instruction_read <= 1'b0;
        i_cached           <= 1'b0;
        i_in_miss_queue    <= 1'b0;
        cur_bsl            = 4'd6;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the settings from reset: 64-byte blocks, limit 16,
        // no squash, cached checked at issue, instruction misses accepted.
        put_item(mk_issue(1'b0));                  // issue while empty
        it = noise_item();
        it.cmd = CMD_UNUSED;
        put_item(it);                              // unknown command does nothing
        put_item(mk_cand(48'h0000_0000_1000, 16'd5, 1'b0, 1'b0));  // no miss yet
        put_item(mk_miss(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFF0, 8'hFF, 1'b0, 1'b0));
        put_item(mk_cand(48'hFFFF_FFFF_FFC0, 16'hFFFF, 1'b0, 1'b0)); // ready time wraps
        put_item(mk_cand(48'hFFFF_FFFF_FFC0, 16'h0000, 1'b0, 1'b0)); // already queued
        put_item(mk_cand(48'h0000_0000_0000, 16'h0000, 1'b0, 1'b1)); // in the miss queue
        // Cached does not block an insert while the check is made at issue.
        put_item(mk_cand(48'h0000_0000_0000, 16'h0000, 1'b1, 1'b0));
        // An unaligned candidate never matches a masked entry, so it goes in twice.
        put_item(mk_cand(48'h1234_5678_9A01, 16'h0001, 1'b0, 1'b0));
        put_item(mk_cand(48'h1234_5678_9A01, 16'h0002, 1'b0, 1'b0));
        // A miss inside a queued block removes that entry.
        put_item(mk_miss(48'hFFFF_FFFF_FFC5, 48'h0, 8'h00, 1'b0, 1'b0));
        put_item(mk_issue(1'b1));                  // cached head is dropped
        put_item(mk_issue(1'b0));                  // head is issued
        put_item(mk_miss(48'h5555_5555_5555, 48'h10, 8'h5A, 1'b1, 1'b0)); // uncacheable
        put_item(mk_cand(48'hAAAA_AAAA_AA80, 16'h3, 1'b0, 1'b0));  // ignored after it
        put_item(mk_miss(48'hAAAA_AAAA_AAAA, 48'h20, 8'hA5, 1'b0, 1'b1)); // fetch accepted
        wait_until_drained();

        // Byte blocks, limit 0 (acts as 1), squash on, cached checked at insert,
        // instruction misses ignored.
        load_settings(5'd0, 5'd0, 1'b1, 1'b1, 1'b1);
        put_item(mk_miss(48'h0000_0000_0040, 48'd100, 8'h11, 1'b0, 1'b1)); // rejected
        put_item(mk_miss(48'h0000_0000_0040, 48'd100, 8'h11, 1'b0, 1'b0));
        put_item(mk_cand(48'h0000_0000_0100, 16'd50, 1'b1, 1'b0));  // cached, skipped
        put_item(mk_cand(48'h0000_0000_0100, 16'd50, 1'b0, 1'b0));  // fills the queue
        put_item(mk_cand(48'h0000_0000_0101, 16'd10, 1'b0, 1'b0));  // evicts the head
        // The tail entry is ready at 110, at or after this miss, so it is squashed.
        put_item(mk_miss(48'h0000_0000_0200, 48'd105, 8'h22, 1'b0, 1'b0));
        put_item(mk_cand(48'h0000_0000_0300, 16'd3, 1'b0, 1'b0));
        put_item(mk_issue(1'b1));                  // cached ignored at issue here
        put_item(mk_issue(1'b0));                  // empty again
        wait_until_drained();

        // Random phases, each under its own settings. Lowering the limit between
        // phases leaves the queue over it, so the next insert evicts several.
        for (p = 0; p < PHASES; p++) begin
            load_settings(ph_bsl[p], ph_limit[p], ph_squash[p], ph_insert[p], ph_donly[p]);
            tx_gaps = ph_txgap[p];
            rx_gaps = ph_rxgap[p];
            for (int k = 0; k < 8; k++) begin
                blk_pool[k] = align_block(random_addr());
            end
            // One phase starts just below the top of the time range so that
            // miss times and ready times wrap around.
            tick_now = (p == 4) ? 48'hFFFF_FFFF_F000 : t_time'(random_addr());
            if (p == 2) rx_hold_len = 250;
            run_phase(PHASE_ITEMS);
            wait_until_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (40) @(posedge i_clk);
        if (checker_mismatches == 0 && checker_waiting == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Far beyond the slowest correct run: every item with the longest sender gap,
    // the longest eviction walk and the longest receiver stall, plus the hold-off.
    initial begin : watchdog
        #8000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/prq_pkg.sv
rtl/prq_cell.sv
rtl/prefetch_request_queue.sv
tb/sv/prq_checker.sv
tb/sv/tb_top.sv
